>>> rtl/rscb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rscb_pkg: shared types and constants of the rectangle stamp collision buffer
// pixel buffer geometry, request and result layouts, walk bounds, clamps
// ----------------------------------------------------------------------------
package rscb_pkg;

  // buffer geometry
  localparam int MAX_COLUMNS = 256;
  localparam int MAX_ROWS    = 64;
  localparam int ID_BITS     = 8;

  // address fields: row above column, columns padded to a power of two
  localparam int COL_BITS  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int ROW_BITS  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int ADDR_W    = COL_BITS + ROW_BITS;
  localparam int RAM_DEPTH = MAX_ROWS * (1 << COL_BITS);

  // coordinate counters hold values up to and including the dimension
  localparam int X_W = $clog2(MAX_COLUMNS + 1);
  localparam int Y_W = $clog2(MAX_ROWS + 1);

  // widths for position plus extent sums
  localparam int XS_W = (X_W > 10) ? X_W : 10;
  localparam int YS_W = (Y_W > 8) ? Y_W : 8;

  // request kinds
  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_STAMP = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // configuration register indexes
  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  localparam logic [8:0] CFG_WIDTH_RESET  = 9'd256;
  localparam logic [6:0] CFG_HEIGHT_RESET = 7'd64;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] pos_x;
    logic [5:0] pos_y;
    logic [8:0] rect_width;
    logic [6:0] rect_height;
    logic [7:0] object_id;
  } request_t;

  typedef struct packed {
    logic       collided;
    logic [7:0] found_id;
  } result_t;

  // rectangle walked by the step unit: x runs x_lo .. x_end-1, y up to y_end-1
  typedef struct packed {
    logic [X_W-1:0] x_lo;
    logic [X_W-1:0] x_end;
    logic [Y_W-1:0] y_end;
  } walk_bounds_t;

  typedef struct packed {
    logic [X_W-1:0] x_next;
    logic [Y_W-1:0] y_next;
    logic           last;
  } step_t;

  function automatic logic [X_W-1:0] clamp_cols(input logic [8:0] v);
    logic [X_W-1:0] r;
    if (v == 9'd0) begin
      r = X_W'(1);
    end else if (int'(v) > MAX_COLUMNS) begin
      r = X_W'(MAX_COLUMNS);
    end else begin
      r = X_W'(v);
    end
    return r;
  endfunction

  function automatic logic [Y_W-1:0] clamp_rows(input logic [6:0] v);
    logic [Y_W-1:0] r;
    if (v == 7'd0) begin
      r = Y_W'(1);
    end else if (int'(v) > MAX_ROWS) begin
      r = Y_W'(MAX_ROWS);
    end else begin
      r = Y_W'(v);
    end
    return r;
  endfunction

endpackage

>>> rtl/rscb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rscb_ram: generic simple dual port ram
// one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module rscb_ram #(
  parameter int  WIDTH  = 8,
  parameter int  DEPTH  = 256,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/rscb_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rscb_step: shared raster step unit
// advances a pixel coordinate left to right, row by row, flags the last pixel
// ----------------------------------------------------------------------------
module rscb_step (
  input  logic [rscb_pkg::X_W-1:0] x,
  input  logic [rscb_pkg::Y_W-1:0] y,
  input  rscb_pkg::walk_bounds_t   bounds,
  output rscb_pkg::step_t          step
);

  logic [rscb_pkg::X_W-1:0] x_inc;
  logic [rscb_pkg::Y_W-1:0] y_inc;
  logic                     row_end;

  assign x_inc   = rscb_pkg::X_W'(x + 1'b1);
  assign y_inc   = rscb_pkg::Y_W'(y + 1'b1);
  assign row_end = (x_inc == bounds.x_end);

  assign step.x_next = row_end ? bounds.x_lo : x_inc;
  assign step.y_next = row_end ? y_inc : y;
  assign step.last   = row_end && (y_inc == bounds.y_end);

endmodule

>>> rtl/rect_stamp_collision_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_stamp_collision_buffer: object id pixel buffer with collision stamping
// clear, rectangle stamp with first-hit collision report, single pixel read
// ----------------------------------------------------------------------------
//
//  channel   ports                          moves
//  --------  -----------------------------  ----------------------------------
//  request   start, busy, request           accepted when start & !busy
//  result    done, result                   one cycle strobe, cannot stall
//  config    cfg_we, cfg_index, cfg_data    write when cfg_we, no wait
//
//  read: the ram is read on accept; the registered data is reported from the wait state with done
//  stamp: one pixel per cycle, the read of the
//    next pixel overlaps the check and write of the current one; a rectangle
//    that clips to nothing answers straight from the idle state
//  clear: all MAX_ROWS * MAX_COLUMNS ram entries (16384), one ram entry per cycle
//  reset runs the same clearing pass with busy high and no result
//  the result has no back pressure: done is a single cycle strobe
//
module rect_stamp_collision_buffer (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  rscb_pkg::request_t request,
  output logic               done,
  output rscb_pkg::result_t  result,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [8:0]         cfg_data
);

  // sequencer states
  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_WALK   = 3'd2;
  localparam logic [2:0] S_RDWAIT = 3'd3;

  localparam rscb_pkg::walk_bounds_t CLEAR_BOUNDS = '{
    x_lo:  '0,
    x_end: rscb_pkg::X_W'(rscb_pkg::MAX_COLUMNS),
    y_end: rscb_pkg::Y_W'(rscb_pkg::MAX_ROWS)
  };

  // configuration
  logic [8:0] cfg_width;
  logic [6:0] cfg_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= rscb_pkg::CFG_WIDTH_RESET;
      cfg_height <= rscb_pkg::CFG_HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rscb_pkg::CFG_IDX_WIDTH:  cfg_width  <= cfg_data;
        rscb_pkg::CFG_IDX_HEIGHT: cfg_height <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // sequencer and walk registers
  logic [2:0]                     state;
  logic [rscb_pkg::X_W-1:0]       x;
  logic [rscb_pkg::Y_W-1:0]       y;
  rscb_pkg::walk_bounds_t         bounds;
  logic                           clear_report;
  logic                           issue_done;
  logic                           chk_valid;
  logic                           chk_last;
  logic [rscb_pkg::ADDR_W-1:0]    chk_addr;
  logic [rscb_pkg::ID_BITS-1:0]   stamp_id;

  rscb_pkg::step_t step;

  // ram ports
  logic                           ram_we;
  logic [rscb_pkg::ADDR_W-1:0]    ram_waddr;
  logic [rscb_pkg::ID_BITS-1:0]   ram_wdata;
  logic                           ram_re;
  logic [rscb_pkg::ADDR_W-1:0]    ram_raddr;
  logic [rscb_pkg::ID_BITS-1:0]   ram_rdata;

  // area in use and request geometry
  logic [rscb_pkg::X_W-1:0]  cols;
  logic [rscb_pkg::Y_W-1:0]  rows;
  logic [rscb_pkg::XS_W-1:0] req_x0;
  logic [rscb_pkg::YS_W-1:0] req_y0;
  logic [rscb_pkg::XS_W-1:0] x_end_raw;
  logic [rscb_pkg::YS_W-1:0] y_end_raw;
  logic [rscb_pkg::XS_W-1:0] x_end_clip;
  logic [rscb_pkg::YS_W-1:0] y_end_clip;
  logic                      stamp_empty;
  logic                      in_area;
  logic                      accept;
  logic                      hit;

  logic [rscb_pkg::ADDR_W-1:0] walk_addr;
  logic [rscb_pkg::ADDR_W-1:0] req_addr;

  assign cols = rscb_pkg::clamp_cols(cfg_width);
  assign rows = rscb_pkg::clamp_rows(cfg_height);

  assign req_x0    = rscb_pkg::XS_W'(request.pos_x);
  assign req_y0    = rscb_pkg::YS_W'(request.pos_y);
  assign x_end_raw = req_x0 + rscb_pkg::XS_W'(request.rect_width);
  assign y_end_raw = req_y0 + rscb_pkg::YS_W'(request.rect_height);

  // clip each axis to the area in use
  assign x_end_clip = (x_end_raw > rscb_pkg::XS_W'(cols)) ? rscb_pkg::XS_W'(cols) : x_end_raw;
  assign y_end_clip = (y_end_raw > rscb_pkg::YS_W'(rows)) ? rscb_pkg::YS_W'(rows) : y_end_raw;

  // zero extent or fully outside: nothing to walk
  assign stamp_empty = (req_x0 >= x_end_clip) || (req_y0 >= y_end_clip);

  assign in_area = (req_x0 < rscb_pkg::XS_W'(cols)) && (req_y0 < rscb_pkg::YS_W'(rows));

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  assign walk_addr = {y[rscb_pkg::ROW_BITS-1:0], x[rscb_pkg::COL_BITS-1:0]};
  assign req_addr  = {rscb_pkg::ROW_BITS'(request.pos_y), rscb_pkg::COL_BITS'(request.pos_x)};

  // pixel under check is occupied
  assign hit = chk_valid && (ram_rdata != '0);

  rscb_step u_step (
    .x      (x),
    .y      (y),
    .bounds (bounds),
    .step   (step)
  );

  // ram port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = walk_addr;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = walk_addr;
    case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_IDLE: begin
        if (accept && (request.kind == rscb_pkg::KIND_READ) && in_area) begin
          ram_re    = 1'b1;
          ram_raddr = req_addr;
        end
      end
      S_WALK: begin
        // write the checked pixel while the next one is read
        if (chk_valid && !hit) begin
          ram_we    = 1'b1;
          ram_waddr = chk_addr;
          ram_wdata = stamp_id;
        end
        ram_re = !issue_done;
      end
      default: ;
    endcase
  end

  rscb_ram #(
    .WIDTH (rscb_pkg::ID_BITS),
    .DEPTH (rscb_pkg::RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      x            <= '0;
      y            <= '0;
      bounds       <= CLEAR_BOUNDS;
      clear_report <= 1'b0;
      issue_done   <= 1'b0;
      chk_valid    <= 1'b0;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          x <= step.x_next;
          y <= step.y_next;
          if (step.last) begin
            state        <= S_IDLE;
            clear_report <= 1'b0;
            // the pass after reset answers no request
            if (clear_report) begin
              done   <= 1'b1;
              result <= '0;
            end
          end
        end
        S_IDLE: begin
          if (accept) begin
            case (request.kind)
              rscb_pkg::KIND_CLEAR: begin
                state        <= S_CLEAR;
                x            <= '0;
                y            <= '0;
                bounds       <= CLEAR_BOUNDS;
                clear_report <= 1'b1;
              end
              rscb_pkg::KIND_STAMP: begin
                if (stamp_empty) begin
                  done   <= 1'b1;
                  result <= '0;
                end else begin
                  state        <= S_WALK;
                  x            <= rscb_pkg::X_W'(req_x0);
                  y            <= rscb_pkg::Y_W'(req_y0);
                  bounds.x_lo  <= rscb_pkg::X_W'(req_x0);
                  bounds.x_end <= rscb_pkg::X_W'(x_end_clip);
                  bounds.y_end <= rscb_pkg::Y_W'(y_end_clip);
                  stamp_id     <= rscb_pkg::ID_BITS'(request.object_id);
                  issue_done   <= 1'b0;
                  chk_valid    <= 1'b0;
                end
              end
              rscb_pkg::KIND_READ: begin
                if (in_area) begin
                  state <= S_RDWAIT;
                end else begin
                  done   <= 1'b1;
                  result <= '0;
                end
              end
              default: begin
                // no operation
                done   <= 1'b1;
                result <= '0;
              end
            endcase
          end
        end
        S_RDWAIT: begin
          state           <= S_IDLE;
          done            <= 1'b1;
          result.collided <= 1'b0;
          result.found_id <= 8'(ram_rdata);
        end
        S_WALK: begin
          if (hit) begin
            // first occupied pixel ends the stamp
            state           <= S_IDLE;
            chk_valid       <= 1'b0;
            done            <= 1'b1;
            result.collided <= 1'b1;
            result.found_id <= 8'(ram_rdata);
          end else if (chk_valid && chk_last) begin
            state     <= S_IDLE;
            chk_valid <= 1'b0;
            done      <= 1'b1;
            result    <= '0;
          end else if (!issue_done) begin
            chk_valid  <= 1'b1;
            chk_addr   <= walk_addr;
            chk_last   <= step.last;
            x          <= step.x_next;
            y          <= step.y_next;
            issue_done <= step.last;
          end else begin
            chk_valid <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
